// ===== sv/mssm_pkg.sv =====
// Shared types, codes and constants for the multi-stack shared memory block.
package mssm_pkg;

  localparam int MEM_DEPTH_DEF   = 32;
  localparam int STACK_SLOTS_DEF = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int TOTAL_W    = 6;
  localparam int STACKS_W   = 4;
  localparam int ID_W       = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int IN_USER_W  = 1 + ID_W;
  localparam int DIV_CNT_W  = 3;

  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = TOTAL_W'(32);
  localparam logic [STACKS_W-1:0] STACKS_RST = STACKS_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STACKS = CFG_IDX_W'(1);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_READ = 2'd2
  } state_t;

  typedef struct packed {
    logic cfg_take;
    logic div_step;
    logic take;
    logic load_read;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic need_read;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/mssm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/mssm_datapath.sv =====
// Datapath: config registers, partition divider, fill counts, entry RAM, result register.
module mssm_datapath #(
  parameter int MEM_DEPTH   = mssm_pkg::MEM_DEPTH_DEF,
  parameter int STACK_SLOTS = mssm_pkg::STACK_SLOTS_DEF,
  parameter int DATA_WIDTH  = mssm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mssm_pkg::cmd_t                      cmd,
  output mssm_pkg::sts_t                      sts,
  input  logic [mssm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mssm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_req_type,
  input  logic [mssm_pkg::ID_W-1:0]           in_stack_id,
  input  logic [mssm_pkg::VALUE_W-1:0]        in_push_value,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [mssm_pkg::STATUS_W-1:0]       out_status,
  output logic [mssm_pkg::VALUE_W-1:0]        out_pop_value
);

  localparam int TW  = mssm_pkg::TOTAL_W;
  localparam int NW  = mssm_pkg::STACKS_W;
  localparam int IW  = mssm_pkg::ID_W;
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int XW  = (AW > TW) ? AW : TW;
  localparam int SW  = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int IXW = (SW > IW) ? SW : IW;
  localparam int TMAX_I = (MEM_DEPTH > (2**TW - 1)) ? (2**TW - 1) : MEM_DEPTH;
  localparam int NMAX_I = (STACK_SLOTS > (2**NW - 1)) ? (2**NW - 1) : STACK_SLOTS;
  localparam logic [TW-1:0] TMAX = TW'(TMAX_I);
  localparam logic [NW-1:0] NMAX = NW'(NMAX_I);
  localparam logic [TW-1:0] T_RST =
    (mssm_pkg::TOTAL_RST > TMAX) ? TMAX : mssm_pkg::TOTAL_RST;
  localparam logic [NW-1:0] N_RST =
    (mssm_pkg::STACKS_RST > NMAX) ? NMAX : mssm_pkg::STACKS_RST;
  localparam logic [mssm_pkg::DIV_CNT_W-1:0] DIV_LAST =
    mssm_pkg::DIV_CNT_W'(TW - 1);

  logic [TW-1:0]                  eff_t_r, eff_t_nxt;
  logic [NW-1:0]                  eff_n_r, eff_n_nxt;
  logic [TW-1:0]                  part_r, part_nxt;
  logic [TW-1:0]                  div_q_r, div_q_nxt;
  logic [NW-1:0]                  div_rem_r, div_rem_nxt;
  logic [mssm_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [TW-1:0]                  fill_r [STACK_SLOTS];
  logic [TW-1:0]                  fill_nxt [STACK_SLOTS];
  logic                           out_vld_r, out_vld_nxt;
  logic [mssm_pkg::STATUS_W-1:0]  out_st_r, out_st_nxt;
  logic [mssm_pkg::VALUE_W-1:0]   out_val_r, out_val_nxt;

  logic [NW:0]          trial;
  logic                 trial_ge;
  logic [IXW-1:0]       id_x;
  logic [SW-1:0]        idx;
  logic                 bad;
  logic                 last;
  logic [TW-1:0]        start;
  logic [TW-1:0]        cap;
  logic [TW-1:0]        fill_sel;
  logic                 full;
  logic                 empty;
  logic [TW-1:0]        base;
  logic [TW-1:0]        addr6;
  logic [XW-1:0]        addr_x;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 cfg_listed;
  mssm_pkg::status_t    res_st;
  logic                 ram_wr;
  logic                 ram_rd;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  function automatic logic [TW-1:0] clamp_t(input logic [TW-1:0] v);
    if (v == '0) begin
      return TW'(1);
    end
    return (v > TMAX) ? TMAX : v;
  endfunction

  function automatic logic [NW-1:0] clamp_n(input logic [NW-1:0] v);
    if (v == '0) begin
      return NW'(1);
    end
    return (v > NMAX) ? NMAX : v;
  endfunction

  // restoring divide, one quotient bit per step
  assign trial    = {div_rem_r, div_q_r[TW-1]};
  assign trial_ge = trial >= {1'b0, eff_n_r};

  // only writes to a listed register empty the stacks
  assign cfg_listed = (cfg_index == mssm_pkg::REG_TOTAL_SIZE) ||
                      (cfg_index == mssm_pkg::REG_NUM_STACKS);

  // request decode
  assign id_x     = IXW'(in_stack_id);
  assign idx      = id_x[SW-1:0];
  assign bad      = NW'(in_stack_id) >= eff_n_r;
  assign last     = NW'(in_stack_id) == (eff_n_r - NW'(1));
  assign start    = TW'(in_stack_id * part_r);
  assign cap      = last ? (eff_t_r - start) : part_r;
  assign fill_sel = fill_r[idx];
  assign full     = fill_sel >= cap;
  assign empty    = fill_sel == '0;
  assign base     = start + fill_sel;
  assign addr6    = (in_req_type == mssm_pkg::REQ_POP) ? (base - TW'(1)) : base;
  assign addr_x   = XW'(addr6);
  assign push_ok  = !bad && (in_req_type == mssm_pkg::REQ_PUSH) && !full;
  assign pop_ok   = !bad && (in_req_type == mssm_pkg::REQ_POP) && !empty;

  always_comb begin
    if (bad) begin
      res_st = mssm_pkg::ST_BAD;
    end else if (in_req_type == mssm_pkg::REQ_PUSH) begin
      res_st = full ? mssm_pkg::ST_FULL : mssm_pkg::ST_OK;
    end else begin
      res_st = empty ? mssm_pkg::ST_EMPTY : mssm_pkg::ST_OK;
    end
  end

  assign ram_wr = cmd.take && push_ok;
  assign ram_rd = cmd.take && pop_ok;

  mssm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(addr_x[AW-1:0]),
    .wr_data(DATA_WIDTH'($signed(in_push_value))),
    .rd_en  (ram_rd),
    .rd_addr(addr_x[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    eff_t_nxt   = eff_t_r;
    eff_n_nxt   = eff_n_r;
    part_nxt    = part_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_cnt_nxt = div_cnt_r;
    for (int i = 0; i < STACK_SLOTS; i++) begin
      fill_nxt[i] = fill_r[i];
    end
    if (cmd.cfg_take) begin
      if (cfg_index == mssm_pkg::REG_TOTAL_SIZE) begin
        eff_t_nxt = clamp_t(cfg_data[TW-1:0]);
      end
      if (cfg_index == mssm_pkg::REG_NUM_STACKS) begin
        eff_n_nxt = clamp_n(cfg_data[NW-1:0]);
      end
      div_q_nxt   = eff_t_nxt;
      div_rem_nxt = '0;
      div_cnt_nxt = '0;
      if (cfg_listed) begin
        for (int i = 0; i < STACK_SLOTS; i++) begin
          fill_nxt[i] = '0;
        end
      end
    end else if (cmd.div_step) begin
      div_q_nxt   = {div_q_r[TW-2:0], trial_ge};
      div_rem_nxt = trial_ge ? NW'(trial - {1'b0, eff_n_r}) : trial[NW-1:0];
      div_cnt_nxt = div_cnt_r + mssm_pkg::DIV_CNT_W'(1);
      if (div_cnt_r == DIV_LAST) begin
        part_nxt = div_q_nxt;
      end
    end else if (cmd.take) begin
      if (push_ok) begin
        fill_nxt[idx] = fill_sel + TW'(1);
      end else if (pop_ok) begin
        fill_nxt[idx] = fill_sel - TW'(1);
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_st_nxt  = out_st_r;
    out_val_nxt = out_val_r;
    if (cmd.take && !pop_ok) begin
      out_vld_nxt = 1'b1;
      out_st_nxt  = res_st;
      out_val_nxt = '0;
    end else if (cmd.load_read) begin
      out_vld_nxt = 1'b1;
      out_st_nxt  = mssm_pkg::ST_OK;
      out_val_nxt = mssm_pkg::VALUE_W'($signed(ram_rd_data));
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_t_r   <= T_RST;
      eff_n_r   <= N_RST;
      part_r    <= T_RST / N_RST;
      div_cnt_r <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < STACK_SLOTS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      eff_t_r   <= eff_t_nxt;
      eff_n_r   <= eff_n_nxt;
      part_r    <= part_nxt;
      div_cnt_r <= div_cnt_nxt;
      out_vld_r <= out_vld_nxt;
      for (int i = 0; i < STACK_SLOTS; i++) begin
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
  end

  assign sts.div_last  = div_cnt_r == DIV_LAST;
  assign sts.need_read = pop_ok;
  assign sts.out_free  = !out_vld_r || out_tready;

  assign out_tvalid    = out_vld_r;
  assign out_status    = out_st_r;
  assign out_pop_value = out_val_r;

  a_read_lands_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_read |-> !out_vld_r)
    else $error("pop data arrived while result register busy");

  a_read_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_read |-> !cmd.take && !cmd.cfg_take)
    else $error("transaction taken during pop read");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cfg_take && cfg_listed) |=> fill_r[0] == '0)
    else $error("config write did not empty stacks");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && push_ok) |=> fill_r[$past(idx)] == $past(fill_sel) + TW'(1))
    else $error("push did not advance fill count");

  a_fill_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && push_ok) |=> fill_r[$past(idx)] <= $past(cap))
    else $error("fill count beyond stack capacity");

endmodule

// ===== sv/mssm_ctrl.sv =====
// Controller: sequences config divide, request acceptance and pop read.
module mssm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  mssm_pkg::sts_t sts,
  output mssm_pkg::cmd_t cmd
);

  mssm_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mssm_pkg::S_IDLE: begin
        if (cmd.cfg_take) begin
          state_nxt = mssm_pkg::S_DIV;
        end else if (cmd.take && sts.need_read) begin
          state_nxt = mssm_pkg::S_READ;
        end
      end
      mssm_pkg::S_DIV: begin
        if (sts.div_last) begin
          state_nxt = mssm_pkg::S_IDLE;
        end
      end
      mssm_pkg::S_READ: begin
        state_nxt = mssm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mssm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cfg_ready     = 1'b0;
    in_tready     = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.load_read = 1'b0;
    unique case (state_r)
      mssm_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = !cfg_valid && sts.out_free;
      end
      mssm_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      mssm_pkg::S_READ: begin
        cmd.load_read = 1'b1;
      end
      default: begin
        cfg_ready = 1'b0;
      end
    endcase
    cmd.cfg_take = cfg_valid && cfg_ready;
    cmd.take     = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mssm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/multi_stack_shared_memory.sv =====
// Top level of the multi-stack shared memory block.
// Up to STACK_SLOTS LIFO stacks share one MEM_DEPTH-entry RAM in fixed partitions of
// floor(total_size / num_stacks) entries; the last stack takes the remainder. Each
// input transaction (tuser: req_type, stack_id; tdata: push value) gives exactly one
// result transaction (tuser: status; tdata: popped value or zero). A push, a refused
// request or a bad index has its result registered as it is taken; a successful pop
// first passes through the S_READ state for the registered read of the entry RAM. A
// result waits in an output register, and the next request is taken no earlier than
// the edge at which that result is accepted. A write to total_size or num_stacks
// empties all stacks; every configuration write starts a bit-serial divide of the
// partition size, during which no request is taken. No clearing pass follows reset.
module multi_stack_shared_memory #(
  parameter int MEM_DEPTH   = mssm_pkg::MEM_DEPTH_DEF,
  parameter int STACK_SLOTS = mssm_pkg::STACK_SLOTS_DEF,
  parameter int DATA_WIDTH  = mssm_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mssm_pkg::VALUE_W-1:0]    in_tdata,   // push_value
  input  logic [mssm_pkg::IN_USER_W-1:0]  in_tuser,   // req_type, stack_id
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mssm_pkg::VALUE_W-1:0]    out_tdata,  // pop_value
  output logic [mssm_pkg::STATUS_W-1:0]   out_tuser,  // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mssm_pkg::CFG_DATA_W-1:0] cfg_data
);

  mssm_pkg::cmd_t cmd;
  mssm_pkg::sts_t sts;

  mssm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mssm_datapath #(
    .MEM_DEPTH  (MEM_DEPTH),
    .STACK_SLOTS(STACK_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (in_tuser[0]),
    .in_stack_id  (in_tuser[mssm_pkg::IN_USER_W-1:1]),
    .in_push_value(in_tdata),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (out_tuser),
    .out_pop_value(out_tdata)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the multi-stack shared memory block.
module testbench;

  localparam int WATCHDOG_LIMIT = 200;

  typedef struct {
    mssm_pkg::status_t status;
    logic [31:0]       value;
  } stack_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mssm_pkg::VALUE_W-1:0]    in_tdata = '0;   // push_value
  logic [mssm_pkg::IN_USER_W-1:0]  in_tuser = '0;   // req_type, stack_id
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  logic [mssm_pkg::VALUE_W-1:0]    out_tdata;       // pop_value
  logic [mssm_pkg::STATUS_W-1:0]   out_tuser;       // status
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mssm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mssm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multi_stack_shared_memory dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow state of the stacks
  logic [31:0]                   entries [0:mssm_pkg::MEM_DEPTH_DEF-1];
  int                            fill [0:mssm_pkg::STACK_SLOTS_DEF-1];
  logic [mssm_pkg::TOTAL_W-1:0]  reg_total = mssm_pkg::TOTAL_RST;
  logic [mssm_pkg::STACKS_W-1:0] reg_stacks = mssm_pkg::STACKS_RST;
  int                            eff_total;
  int                            eff_stacks;
  int                            part;

  stack_result_t pending_results[$];
  int  errors = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  status_seen [0:3];
  bit  idle_on = 1'b1;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_stacks();
    for (int i = 0; i < mssm_pkg::STACK_SLOTS_DEF; i++) fill[i] = 0;
  endfunction

  function automatic void apply_layout();
    int t;
    int n;
    t = reg_total;
    n = reg_stacks;
    if (t < 1) t = 1;
    if (t > mssm_pkg::MEM_DEPTH_DEF) t = mssm_pkg::MEM_DEPTH_DEF;
    if (n < 1) n = 1;
    if (n > mssm_pkg::STACK_SLOTS_DEF) n = mssm_pkg::STACK_SLOTS_DEF;
    eff_total  = t;
    eff_stacks = n;
    part       = t / n;
    clear_stacks();
  endfunction

  function automatic void stack_predict(logic op, logic [mssm_pkg::ID_W-1:0] id,
                                        logic [31:0] v);
    stack_result_t r;
    int start;
    int cap;
    r.status = mssm_pkg::ST_OK;
    r.value  = '0;
    if (int'(id) >= eff_stacks) begin
      r.status = mssm_pkg::ST_BAD;
    end else begin
      start = id * part;
      cap   = (int'(id) == eff_stacks - 1) ? eff_total - start : part;
      if (op == mssm_pkg::REQ_PUSH) begin
        if (fill[id] >= cap) begin
          r.status = mssm_pkg::ST_FULL;
        end else begin
          entries[start + fill[id]] = v;
          fill[id]++;
        end
      end else if (fill[id] == 0) begin
        r.status = mssm_pkg::ST_EMPTY;
      end else begin
        fill[id]--;
        r.value = entries[start + fill[id]];
      end
    end
    status_seen[r.status]++;
    pending_results.push_back(r);
  endfunction

  task automatic send_req(input logic op, input logic [mssm_pkg::ID_W-1:0] id,
                          input logic [31:0] v);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {id, op};
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    stack_predict(op, id, v);
    items_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mssm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mssm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mssm_pkg::REG_TOTAL_SIZE) begin
      reg_total = val[mssm_pkg::TOTAL_W-1:0];
      apply_layout();
    end else if (idx == mssm_pkg::REG_NUM_STACKS) begin
      reg_stacks = val[mssm_pkg::STACKS_W-1:0];
      apply_layout();
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_layout(input logic [mssm_pkg::TOTAL_W-1:0] t,
                            input logic [mssm_pkg::STACKS_W-1:0] n);
    drain();
    write_reg(mssm_pkg::REG_TOTAL_SIZE,
              {(mssm_pkg::CFG_DATA_W - mssm_pkg::TOTAL_W)'($urandom), t});
    write_reg(mssm_pkg::REG_NUM_STACKS,
              {(mssm_pkg::CFG_DATA_W - mssm_pkg::STACKS_W)'($urandom), n});
  endtask

  task automatic test_reset_layout();
    send_req(mssm_pkg::REQ_POP,  3'd0, 32'd0);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'h8000_0000);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'hFFFF_FFFF);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'h0000_0000);
    send_req(mssm_pkg::REQ_PUSH, 3'd1, 32'h1234_5678);
    send_req(mssm_pkg::REQ_POP,  3'd7, 32'hFFFF_FFFF);
    repeat (4) send_req(mssm_pkg::REQ_POP, 3'd0, 32'hA5A5_A5A5);
  endtask

  task automatic test_full_and_empty();
    set_layout(6'd3, 4'd2);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'd11);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'd12);
    repeat (3) send_req(mssm_pkg::REQ_PUSH, 3'd1, $urandom);
    send_req(mssm_pkg::REQ_POP, 3'd2, 32'd0);
    repeat (3) send_req(mssm_pkg::REQ_POP, 3'd1, 32'd0);
  endtask

  task automatic test_zero_partition();
    set_layout(6'd3, 4'd8);
    send_req(mssm_pkg::REQ_PUSH, 3'd0, 32'd5);
    send_req(mssm_pkg::REQ_PUSH, 3'd7, 32'hDEAD_BEEF);
    send_req(mssm_pkg::REQ_POP,  3'd7, 32'd0);
  endtask

  task automatic test_unlisted_reg_write();
    send_req(mssm_pkg::REQ_PUSH, 3'd7, 32'd77);
    drain();
    write_reg(8'hFF, 8'hFF);
    send_req(mssm_pkg::REQ_POP, 3'd7, 32'd0);
  endtask

  task automatic test_random_phase(input logic [mssm_pkg::TOTAL_W-1:0] t,
                                   input logic [mssm_pkg::STACKS_W-1:0] n,
                                   input int count);
    logic                      op_bias;
    logic                      op;
    logic [mssm_pkg::ID_W-1:0] id;
    set_layout(t, n);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(mssm_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                mssm_pkg::CFG_DATA_W'($urandom));
    end
    op_bias = mssm_pkg::REQ_PUSH;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 4) op_bias = ~op_bias;
      op = ($urandom_range(0, 3) == 0) ? ~op_bias : op_bias;
      if ($urandom_range(0, 9) == 0) id = mssm_pkg::ID_W'($urandom_range(0, 7));
      else id = mssm_pkg::ID_W'($urandom_range(0, eff_stacks - 1));
      send_req(op, id, $urandom);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status || out_tdata !== exp_r.value) begin
          $display("%0t: mismatch expected status=%0d value=%h, actual status=%0d value=%h",
                   $time, exp_r.status, exp_r.value, out_tuser, out_tdata);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < mssm_pkg::MEM_DEPTH_DEF; i++) entries[i] = '0;
    apply_layout();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_layout();
    test_full_and_empty();
    test_zero_partition();
    test_unlisted_reg_write();

    test_random_phase(6'd32, 4'd8,  220);
    test_random_phase(6'd5,  4'd2,  220);
    test_random_phase(6'd3,  4'd8,  220);
    test_random_phase(6'd0,  4'd0,  200);
    test_random_phase(6'd63, 4'd15, 220);
    test_random_phase(6'd17, 4'd5,  220);
    test_random_phase(6'd1,  4'd8,  200);
    test_random_phase(6'd32, 4'd1,  220);
    idle_on = 1'b0;
    test_random_phase(6'd12, 4'd3,  220);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d requests over %0d register writes, clamped and unlisted included",
             items_sent, cfg_writes);
    $display("results: ok %0d, full %0d, empty %0d, bad index %0d",
             status_seen[mssm_pkg::ST_OK], status_seen[mssm_pkg::ST_FULL],
             status_seen[mssm_pkg::ST_EMPTY], status_seen[mssm_pkg::ST_BAD]);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
